[rtl/core/spib_pkg.sv]
package spib_pkg;

	localparam int FUNC_W  = 3;
	localparam int TOTAL_W = 21;
	localparam int START_W = 21;
	localparam int SCNT_W  = 16;
	localparam int POS_W   = 32;
	localparam int LIMIT_W = 16;
	localparam int OFFS_W  = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [FUNC_W-1:0] FUNC_COUNT = 3'd0;
	localparam logic [FUNC_W-1:0] FUNC_FIN   = 3'd1;
	localparam logic [FUNC_W-1:0] FUNC_PLACE = 3'd2;
	localparam logic [FUNC_W-1:0] FUNC_RSEED = 3'd3;
	localparam logic [FUNC_W-1:0] FUNC_RSLOT = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_LIMIT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_POS_OFFSET  = 1'b1;

	localparam logic [LIMIT_W-1:0] COUNT_LIMIT_RST = 16'hFFFF;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_FIN,
		ST_FLAST,
		ST_RESP
	} spib_state_t;

	typedef struct packed {
		logic rd;
		logic wr;
	} pos_cmd_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] total_positions;
		logic [START_W-1:0] seed_start;
		logic [SCNT_W-1:0]  seed_count;
		logic [POS_W-1:0]   stored_position;
		logic               placed;
		logic               overflow;
	} res_t;

endpackage

[rtl/core/spib_pos_store.sv]
module spib_pos_store
	import spib_pkg::*;
#(
	parameter int POS_ADDR_BITS = 20
) (
	input  logic                     clk,
	input  pos_cmd_t                 cmd,
	input  logic [POS_ADDR_BITS-1:0] rd_addr,
	input  logic [POS_ADDR_BITS-1:0] wr_addr,
	input  logic [POS_W-1:0]         position,
	input  logic [OFFS_W-1:0]        offset,
	output logic [POS_W-1:0]         rd_data,
	output logic [POS_W-1:0]         wr_value
);

	localparam int DEPTH = 1 << POS_ADDR_BITS;

	logic [POS_W-1:0] mem [DEPTH];
	logic [POS_W-1:0] rd_data_q;

	// subtract wraps modulo 2^32
	assign wr_value = position - POS_W'(offset);
	assign rd_data  = rd_data_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[wr_addr] <= wr_value;
		end
		if (cmd.rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

[rtl/core/seed_position_index_builder_core.sv]
// Channel   Signals                                   Direction
// --------  ----------------------------------------  ---------------------
// in        in_valid/in_ready: func seed position slot  item into block
// out       out_valid/out_ready: total_positions ...    result out of block
// cfg       cfg_we cfg_index cfg_data                   register writes
//
// Count, place and read items do one seed table read, then the update and
// write back; a stalled output holds the next result until it frees.
// Finalize walks the seed table, one seed table entry per cycle.
// After reset a clearing pass zeroes every seed table entry;
// in_ready stays low until it ends. One item is in flight at a time.
// The output register lets the next item enter while a result waits.
module seed_position_index_builder_core
	import spib_pkg::*;
#(
	parameter int SEED_BITS     = 16,
	parameter int POS_ADDR_BITS = 20,
	parameter int COUNT_BITS    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [FUNC_W-1:0]    func,
	input  logic [15:0]          seed,
	input  logic [POS_W-1:0]     position,
	input  logic [19:0]          slot,

	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [TOTAL_W-1:0]   total_positions,
	output logic [START_W-1:0]   seed_start,
	output logic [SCNT_W-1:0]    seed_count,
	output logic [POS_W-1:0]     stored_position,
	output logic                 placed,
	output logic                 overflow,

	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LIMIT_W-1:0]   cfg_data
);

	localparam int NSEEDS  = 1 << SEED_BITS;
	localparam int ST_W    = POS_ADDR_BITS + 1;
	localparam int WORD_W  = 2 * COUNT_BITS + ST_W;
	localparam int SUM_W   = ((ST_W > COUNT_BITS) ? ST_W : COUNT_BITS) + 1;
	localparam int CMP_W   = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [ST_W-1:0]  STORE_SIZE_T = {1'b1, {POS_ADDR_BITS{1'b0}}};
	localparam logic [SUM_W-1:0] STORE_SIZE_W = SUM_W'(STORE_SIZE_T);

	spib_state_t state_q, state_d;

	logic [SEED_BITS-1:0]  walk_q;
	logic                  walk_step;
	logic                  walk_last;
	logic                  fin_v_s1;
	logic [SEED_BITS-1:0]  fin_idx_s1;

	logic [ST_W-1:0]       total_q;
	logic                  overflow_q;
	logic [LIMIT_W-1:0]    count_limit_q;
	logic [OFFS_W-1:0]     position_offset_q;

	logic [FUNC_W-1:0]     func_q;
	logic [SEED_BITS-1:0]  seed_q;
	logic [POS_W-1:0]      position_q;

	logic                  accept;
	logic                  exec_act;
	logic                  resp_act;
	logic                  out_free;
	logic                  out_load;
	logic                  out_valid_q;
	res_t                  res;
	res_t                  pend_q;
	res_t                  out_q;

	// seed table: {count, fill, start}
	logic [WORD_W-1:0]     seed_mem [NSEEDS];
	logic [WORD_W-1:0]     seed_rd_q;
	logic [SEED_BITS-1:0]  seed_raddr;
	logic                  seed_we;
	logic [SEED_BITS-1:0]  seed_waddr;
	logic [WORD_W-1:0]     seed_wdata;

	logic [COUNT_BITS-1:0] rd_cnt;
	logic [COUNT_BITS-1:0] rd_fill;
	logic [ST_W-1:0]       rd_start;
	logic [COUNT_BITS-1:0] eff_lim;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] fin_kept;
	logic [SUM_W-1:0]      fin_sum;
	logic                  fin_sat;
	logic [SUM_W-1:0]      place_addr;
	logic                  place_ok;

	pos_cmd_t              pos_cmd;
	logic [POS_W-1:0]      pos_rd_data;
	logic [POS_W-1:0]      pos_wr_value;

	assign accept    = in_valid && in_ready;
	assign walk_last = &walk_q;
	assign out_free  = !out_valid_q || out_ready;

	assign rd_cnt   = seed_rd_q[WORD_W-1 -: COUNT_BITS];
	assign rd_fill  = seed_rd_q[ST_W +: COUNT_BITS];
	assign rd_start = seed_rd_q[ST_W-1:0];

	// counter width caps the programmed limit
	assign eff_lim = (CMP_W'(count_limit_q) < CMP_W'(COUNT_MAX)) ?
		COUNT_BITS'(count_limit_q) : COUNT_MAX;

	assign cnt_inc = (rd_cnt < eff_lim) ? rd_cnt + COUNT_BITS'(1) : rd_cnt;

	// drop repetitive seeds, then extend the prefix sum
	assign fin_kept = (rd_cnt >= eff_lim) ? '0 : rd_cnt;
	assign fin_sum  = SUM_W'(total_q) + SUM_W'(fin_kept);
	assign fin_sat  = fin_sum > STORE_SIZE_W;

	assign place_addr = SUM_W'(rd_start) + SUM_W'(rd_fill);
	assign place_ok   = (rd_cnt != '0) && (rd_fill < rd_cnt) &&
		(place_addr < SUM_W'(total_q)) && (place_addr < STORE_SIZE_W);

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (walk_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) state_d = (func == FUNC_FIN) ? ST_FIN : ST_EXEC;
			end
			ST_EXEC: begin
				state_d = out_free ? ST_IDLE : ST_RESP;
			end
			ST_FIN: begin
				if (walk_last) state_d = ST_FLAST;
			end
			ST_FLAST: begin
				state_d = ST_EXEC;
			end
			ST_RESP: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		in_ready  = 1'b0;
		walk_step = 1'b0;
		exec_act  = 1'b0;
		resp_act  = 1'b0;
		case (state_q)
			ST_CLEAR: walk_step = 1'b1;
			ST_IDLE:  in_ready  = 1'b1;
			ST_EXEC:  exec_act  = 1'b1;
			ST_FIN:   walk_step = 1'b1;
			ST_FLAST: ;
			ST_RESP:  resp_act  = 1'b1;
			default:  ;
		endcase
	end

	assign out_load = (exec_act || resp_act) && out_free;

	always_comb begin
		seed_raddr = (state_q == ST_FIN) ? walk_q : SEED_BITS'(seed);
		seed_we    = 1'b0;
		seed_waddr = seed_q;
		seed_wdata = {rd_cnt, rd_fill, rd_start};
		if (state_q == ST_CLEAR) begin
			seed_we    = 1'b1;
			seed_waddr = walk_q;
			seed_wdata = '0;
		end else if (fin_v_s1) begin
			seed_we    = 1'b1;
			seed_waddr = fin_idx_s1;
			seed_wdata = {fin_kept, {COUNT_BITS{1'b0}}, total_q};
		end else if (exec_act && func_q == FUNC_COUNT) begin
			seed_we    = 1'b1;
			seed_wdata = {cnt_inc, rd_fill, rd_start};
		end else if (exec_act && func_q == FUNC_PLACE && place_ok) begin
			seed_we    = 1'b1;
			seed_wdata = {rd_cnt, rd_fill + COUNT_BITS'(1), rd_start};
		end
	end

	always_ff @(posedge clk) begin
		if (seed_we) begin
			seed_mem[seed_waddr] <= seed_wdata;
		end
		seed_rd_q <= seed_mem[seed_raddr];
	end

	assign pos_cmd.rd = accept;
	assign pos_cmd.wr = exec_act && (func_q == FUNC_PLACE) && place_ok;

	spib_pos_store #(
		.POS_ADDR_BITS(POS_ADDR_BITS)
	) u_pos_store (
		.clk      (clk),
		.cmd      (pos_cmd),
		.rd_addr  (POS_ADDR_BITS'(slot)),
		.wr_addr  (place_addr[POS_ADDR_BITS-1:0]),
		.position (position_q),
		.offset   (position_offset_q),
		.rd_data  (pos_rd_data),
		.wr_value (pos_wr_value)
	);

	always_comb begin
		res                 = '0;
		res.total_positions = TOTAL_W'(total_q);
		res.overflow        = overflow_q;
		case (func_q)
			FUNC_COUNT: res.seed_count = SCNT_W'(cnt_inc);
			FUNC_PLACE: begin
				res.seed_count = SCNT_W'(rd_cnt);
				if (place_ok) begin
					res.stored_position = pos_wr_value;
					res.placed          = 1'b1;
				end
			end
			FUNC_RSEED: begin
				res.seed_start = START_W'(rd_start);
				res.seed_count = SCNT_W'(rd_cnt);
			end
			FUNC_RSLOT: res.stored_position = pos_rd_data;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_CLEAR;
			walk_q            <= '0;
			fin_v_s1          <= 1'b0;
			total_q           <= '0;
			overflow_q        <= 1'b0;
			out_valid_q       <= 1'b0;
			count_limit_q     <= COUNT_LIMIT_RST;
			position_offset_q <= '0;
		end else begin
			state_q  <= state_d;
			fin_v_s1 <= (state_q == ST_FIN);
			if (walk_step) begin
				walk_q <= walk_q + SEED_BITS'(1);
			end
			if (accept && func == FUNC_FIN) begin
				total_q    <= '0;
				overflow_q <= 1'b0;
			end else if (fin_v_s1) begin
				total_q <= fin_sat ? STORE_SIZE_T : ST_W'(fin_sum);
				if (fin_sat) overflow_q <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_COUNT_LIMIT: count_limit_q     <= cfg_data;
					CFG_POS_OFFSET:  position_offset_q <= cfg_data[OFFS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		fin_idx_s1 <= walk_q;
		if (accept) begin
			func_q     <= func;
			seed_q     <= SEED_BITS'(seed);
			position_q <= position;
		end
		if (exec_act && !out_free) begin
			pend_q <= res;
		end
		if (out_load) begin
			out_q <= exec_act ? res : pend_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign total_positions = out_q.total_positions;
	assign seed_start      = out_q.seed_start;
	assign seed_count      = out_q.seed_count;
	assign stored_position = out_q.stored_position;
	assign placed          = out_q.placed;
	assign overflow        = out_q.overflow;

`ifndef SYNTHESIS
	a_accept_next: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC || state_q == ST_FIN))
		else $error("accepted item did not start work");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= STORE_SIZE_T)
		else $error("running total above store size");

	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		overflow_q |-> total_q == STORE_SIZE_T)
		else $error("overflow set without saturated total");

	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result overwrote an untaken result");

	a_fin_idx: assert property (@(posedge clk) disable iff (!arst_n)
		fin_v_s1 |-> fin_idx_s1 == $past(walk_q))
		else $error("finalize write index mismatch");
`endif

endmodule
